// ===== hw/rtl/median_predict_with_histogram_top_assert.svh =====
`ifndef MEDIAN_PREDICT_WITH_HISTOGRAM_TOP_ASSERT_SVH
`define MEDIAN_PREDICT_WITH_HISTOGRAM_TOP_ASSERT_SVH

// Assertion that holds in the same cycle as its condition.
`define MPH_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Assertion that holds in the cycle after its condition.
`define MPH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mph_pkg.sv =====
package mph_pkg;

    // Field widths and fixed values.
    localparam int unsigned MAX_LINE_DEFAULT  = 4096;
    localparam int unsigned CFG_W             = 13;
    localparam int unsigned PIX_W             = 8;
    localparam int unsigned COUNT_W           = 32;
    localparam int unsigned HIST_BINS         = 256;
    localparam int unsigned LINE_LENGTH_RESET = 640;
    localparam logic [PIX_W-1:0]   BIAS       = 8'h80;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

    // Queue depths between the parts of the block.
    localparam int unsigned JOB_DEPTH = 4;
    localparam int unsigned OUT_DEPTH = 3;

    typedef enum logic {
        ACT_PUSH = 1'b0,
        ACT_READ = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        PRED_BIAS,
        PRED_LEFT,
        PRED_ABOVE,
        PRED_MEDIAN
    } t_pred;

    // One job handed from the front to the back. The key is the residual
    // for a pixel and the bin number for a histogram read.
    typedef struct packed {
        t_action          action;
        logic [PIX_W-1:0] key;
    } t_job;

    typedef struct packed {
        logic [PIX_W-1:0]   residual;
        logic [COUNT_W-1:0] count;
    } t_result;

    // Median of three unsigned values.
    function automatic logic [PIX_W-1:0] med3(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c);
        logic [PIX_W-1:0] hi;
        logic [PIX_W-1:0] lo;
        logic [PIX_W-1:0] m;
        hi = (a > b) ? a : b;
        lo = (a < b) ? a : b;
        m  = (hi < c) ? hi : c;
        return (m > lo) ? m : lo;
    endfunction

endpackage

// ===== hw/rtl/mph_ifs.sv =====
// Input channel: one beat is a pixel push or a histogram bin read.
interface mph_in_if;
    logic                       valid;
    logic                       ready;
    logic                       action;
    logic [mph_pkg::PIX_W-1:0]  pixel;
    logic                       frame_start;
    logic [mph_pkg::PIX_W-1:0]  bin;

    modport source (output valid, action, pixel, frame_start, bin, input ready);
    modport sink   (input valid, action, pixel, frame_start, bin, output ready);
endinterface

// Output channel: one beat per input beat.
interface mph_out_if;
    logic                         valid;
    logic                         ready;
    logic [mph_pkg::PIX_W-1:0]    residual;
    logic [mph_pkg::COUNT_W-1:0]  count;

    modport source (output valid, residual, count, input ready);
    modport sink   (input valid, residual, count, output ready);
endinterface

// ===== hw/rtl/median_predict_with_histogram_top.sv =====
// Median predictor with residual histogram. Pixels of one plane enter in
// raster order on the input channel and each gives one 8-bit residual
// (pixel minus prediction, modulo 256); the first pixel of a frame is
// predicted by 0x80, the rest of row 0 by the left pixel, the first pixel of
// row 1 by the pixel above, and every later pixel by the median of above,
// left and above+left-aboveleft. Left and above-left wrap across row ends.
// Every residual is counted in a 256-bin saturating histogram; a read beat
// returns one bin's count and clears it. Each input beat gives exactly one
// output beat, in order. The block sustains one beat per clock unless output
// stalls: the line history is a ring of MAX_LINE+1 pixels with one write and
// two read ports, so above and above-left are read in the beat's own cycle,
// and the histogram is a one-write, one-read memory whose read-modify-write
// on back-to-back beats to the same bin is bypassed. A beat passes the
// predict stage, job queue, histogram stage and output buffer. Histogram bins
// read as zero after reset without any clearing pass; the line history holds
// nothing meaningful until written. Write line_length only while the block is
// idle; zero acts as one and values above MAX_LINE act as MAX_LINE.
module median_predict_with_histogram_top #(
    parameter int unsigned MAX_LINE = mph_pkg::MAX_LINE_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    mph_in_if.sink                      i_pix,
    mph_out_if.source                   o_res,
    input  logic                        i_cfg_we,
    input  logic [mph_pkg::CFG_W-1:0]   i_cfg_data
);

    localparam int unsigned QCW = $clog2(mph_pkg::JOB_DEPTH + 1);

    logic           w_push;
    mph_pkg::t_job  w_push_job;
    logic           w_pop;
    mph_pkg::t_job  w_job;
    logic [QCW-1:0] w_q_count;

    // Front: accept, classify, predict.
    mph_front #(
        .MAX_LINE (MAX_LINE)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (i_pix),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_q_count  (w_q_count),
        .o_push     (w_push),
        .o_push_job (w_push_job)
    );

    // Job queue between front and back.
    mph_queue #(
        .DEPTH (mph_pkg::JOB_DEPTH),
        .WIDTH ($bits(mph_pkg::t_job))
    ) u_job_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_job),
        .i_pop       (w_pop),
        .o_head      (w_job),
        .o_count     (w_q_count)
    );

    // Back: histogram update and result delivery.
    mph_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_count (w_q_count),
        .i_job     (w_job),
        .o_pop     (w_pop),
        .o_res     (o_res)
    );

endmodule

// ===== hw/rtl/mph_queue.sv =====
`include "median_predict_with_histogram_top_assert.svh"

module mph_queue #(
    parameter int unsigned DEPTH = mph_pkg::JOB_DEPTH,
    parameter int unsigned WIDTH = $bits(mph_pkg::t_job)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [WIDTH-1:0]             i_push_data,
    input  logic                         i_pop,
    output logic [WIDTH-1:0]             o_head,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic [AW-1:0]    n_wr;
    logic [AW-1:0]    n_rd;
    logic [CW-1:0]    n_count;

    // Pointer advance with wrap at the depth.
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH-1)) ? '0 : r_wr + AW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH-1)) ? '0 : r_rd + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Storage holds payload only.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_count = r_count;

    `MPH_ASSERT_NOW(a_queue_no_overflow, i_clk, i_rst_n, i_push && (r_count == CW'(DEPTH)), i_pop, "beat pushed into a full queue")
    `MPH_ASSERT_NOW(a_queue_no_underflow, i_clk, i_rst_n, i_pop, r_count != '0, "beat popped from an empty queue")

endmodule

// ===== hw/rtl/mph_front.sv =====
`include "median_predict_with_histogram_top_assert.svh"

module mph_front #(
    parameter int unsigned MAX_LINE = mph_pkg::MAX_LINE_DEFAULT
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    mph_in_if.sink                                   i_pix,
    input  logic                                     i_cfg_we,
    input  logic [mph_pkg::CFG_W-1:0]                i_cfg_data,
    input  logic [$clog2(mph_pkg::JOB_DEPTH+1)-1:0]  i_q_count,
    output logic                                     o_push,
    output mph_pkg::t_job                            o_push_job
);

    localparam int unsigned DEPTH = MAX_LINE + 1;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned PW    = $clog2(MAX_LINE + 2);
    localparam int unsigned QCW   = $clog2(mph_pkg::JOB_DEPTH + 1);
    localparam logic [PW-1:0] STRIDE_RESET =
        PW'((mph_pkg::LINE_LENGTH_RESET > MAX_LINE) ? MAX_LINE : mph_pkg::LINE_LENGTH_RESET);

    typedef struct packed {
        mph_pkg::t_action          action;
        logic [mph_pkg::PIX_W-1:0] px;
        logic [mph_pkg::PIX_W-1:0] left;
        mph_pkg::t_pred            pred;
        logic [mph_pkg::PIX_W-1:0] bin;
    } t_f1_entry;

    logic [mph_pkg::PIX_W-1:0] r_line [DEPTH];
    logic [mph_pkg::PIX_W-1:0] r_above;
    logic [mph_pkg::PIX_W-1:0] r_aboveleft;
    logic [PW-1:0]             r_stride;
    logic [AW-1:0]             r_ptr;
    logic [PW-1:0]             r_frame_pos;
    logic [mph_pkg::PIX_W-1:0] r_left;
    logic                      r_f1_valid;
    t_f1_entry                 r_f1;

    logic [PW-1:0]             n_stride;
    logic [PW-1:0]             n_frame_pos;
    logic [AW-1:0]             n_ptr;
    mph_pkg::t_pred            n_pred;
    logic                      w_accept;
    logic                      w_is_push;
    logic [PW-1:0]             w_pos;
    logic [AW:0]               w_sum_a;
    logic [AW:0]               w_sum_al;
    logic [AW-1:0]             w_addr_a;
    logic [AW-1:0]             w_addr_al;
    logic [mph_pkg::PIX_W-1:0] w_grad;
    logic [mph_pkg::PIX_W-1:0] w_pred;
    logic [mph_pkg::PIX_W-1:0] w_res;

    // Take a beat only when the job queue has room for it and for the job
    // already in the predict stage.
    assign i_pix.ready = (({1'b0, i_q_count} + (QCW+1)'(r_f1_valid))
                          < (QCW+1)'(mph_pkg::JOB_DEPTH));
    assign w_accept  = i_pix.valid && i_pix.ready;
    assign w_is_push = (i_pix.action == mph_pkg::ACT_PUSH);

    // Line length written by the host, clamped into the usable range.
    always_comb begin
        if (i_cfg_data == '0) begin
            n_stride = PW'(1);
        end else if (32'(i_cfg_data) > 32'(MAX_LINE)) begin
            n_stride = PW'(MAX_LINE);
        end else begin
            n_stride = PW'(i_cfg_data);
        end
    end

    // Ring addresses of the pixel above and the pixel above-left.
    always_comb begin
        w_sum_a  = (AW+1)'(r_ptr) + (AW+1)'(DEPTH) - (AW+1)'(r_stride);
        w_sum_al = w_sum_a - (AW+1)'(1);
        w_addr_a  = (w_sum_a  >= (AW+1)'(DEPTH)) ? AW'(w_sum_a  - (AW+1)'(DEPTH))
                                                 : AW'(w_sum_a);
        w_addr_al = (w_sum_al >= (AW+1)'(DEPTH)) ? AW'(w_sum_al - (AW+1)'(DEPTH))
                                                 : AW'(w_sum_al);
    end

    // Classify the pixel by its place in the frame.
    always_comb begin
        w_pos = i_pix.frame_start ? '0 : r_frame_pos;
        if (w_pos == '0) begin
            n_pred = mph_pkg::PRED_BIAS;
        end else if (w_pos < r_stride) begin
            n_pred = mph_pkg::PRED_LEFT;
        end else if (w_pos == r_stride) begin
            n_pred = mph_pkg::PRED_ABOVE;
        end else begin
            n_pred = mph_pkg::PRED_MEDIAN;
        end
        n_frame_pos = (w_pos >= r_stride) ? r_stride + PW'(1) : w_pos + PW'(1);
        n_ptr       = (r_ptr == AW'(DEPTH-1)) ? '0 : r_ptr + AW'(1);
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride    <= STRIDE_RESET;
            r_ptr       <= '0;
            r_frame_pos <= '0;
            r_left      <= '0;
            r_f1_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_stride <= n_stride;
            end
            if (w_accept && w_is_push) begin
                r_ptr       <= n_ptr;
                r_frame_pos <= n_frame_pos;
                r_left      <= i_pix.pixel;
            end
            r_f1_valid <= w_accept;
        end
    end

    // Predict stage payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_f1.action <= mph_pkg::t_action'(i_pix.action);
            r_f1.px     <= i_pix.pixel;
            r_f1.left   <= r_left;
            r_f1.pred   <= n_pred;
            r_f1.bin    <= i_pix.bin;
        end
    end

    // Line history: one write per pixel push and two reads per beat, read before write.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            if (w_is_push) begin
                r_line[r_ptr] <= i_pix.pixel;
            end
            r_above     <= r_line[w_addr_a];
            r_aboveleft <= r_line[w_addr_al];
        end
    end

    // Prediction and residual, modulo 256.
    always_comb begin
        w_grad = r_above + r_f1.left - r_aboveleft;
        case (r_f1.pred)
            mph_pkg::PRED_BIAS:   w_pred = mph_pkg::BIAS;
            mph_pkg::PRED_LEFT:   w_pred = r_f1.left;
            mph_pkg::PRED_ABOVE:  w_pred = r_above;
            mph_pkg::PRED_MEDIAN: w_pred = mph_pkg::med3(r_above, r_f1.left, w_grad);
            default:              w_pred = mph_pkg::BIAS;
        endcase
        w_res = r_f1.px - w_pred;
    end

    assign o_push            = r_f1_valid;
    assign o_push_job.action = r_f1.action;
    assign o_push_job.key    = (r_f1.action == mph_pkg::ACT_READ) ? r_f1.bin : w_res;

    `MPH_ASSERT_NOW(a_front_queue_room, i_clk, i_rst_n, r_f1_valid, i_q_count < QCW'(mph_pkg::JOB_DEPTH), "predict stage holds a job with no room in the queue")
    `MPH_ASSERT_NOW(a_front_stride_range, i_clk, i_rst_n, 1'b1, (r_stride != '0) && (32'(r_stride) <= 32'(MAX_LINE)), "line stride out of range")

endmodule

// ===== hw/rtl/mph_back.sv =====
`include "median_predict_with_histogram_top_assert.svh"

module mph_back (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic [$clog2(mph_pkg::JOB_DEPTH+1)-1:0]  i_q_count,
    input  mph_pkg::t_job                            i_job,
    output logic                                     o_pop,
    mph_out_if.source                                o_res
);

    localparam int unsigned OCW = $clog2(mph_pkg::OUT_DEPTH + 1);

    logic [mph_pkg::COUNT_W-1:0] r_hist [mph_pkg::HIST_BINS];
    logic [mph_pkg::HIST_BINS-1:0] r_hvalid;
    logic                          r_b1_valid;
    mph_pkg::t_job                 r_b1_job;
    logic [mph_pkg::COUNT_W-1:0]   r_rd_cnt;
    logic                          r_rd_vld;
    logic                          r_fwd_hit;
    logic [mph_pkg::COUNT_W-1:0]   r_fwd_data;

    logic                          n_fwd_hit;
    logic [mph_pkg::COUNT_W-1:0]   w_cur;
    logic [mph_pkg::COUNT_W-1:0]   w_new;
    mph_pkg::t_result              w_result;
    mph_pkg::t_result              w_head;
    logic [OCW-1:0]                w_out_count;
    logic                          w_out_pop;

    // Pop a job only when the output buffer can take it in the cycle after.
    assign o_pop = (i_q_count != '0) &&
                   (({1'b0, w_out_count} + (OCW+1)'(r_b1_valid))
                    < (OCW+1)'(mph_pkg::OUT_DEPTH));

    // A job popped behind one that writes the same bin takes the written count.
    assign n_fwd_hit = o_pop && r_b1_valid && (r_b1_job.key == i_job.key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
            r_hvalid   <= '0;
        end else begin
            r_b1_valid <= o_pop;
            r_fwd_hit  <= n_fwd_hit;
            if (r_b1_valid) begin
                r_hvalid[r_b1_job.key] <= 1'b1;
            end
        end
    end

    // Histogram read at pop, write in the next cycle.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b1_job <= i_job;
            r_rd_cnt <= r_hist[i_job.key];
            r_rd_vld <= r_hvalid[i_job.key];
        end
        if (r_b1_valid) begin
            r_hist[r_b1_job.key] <= w_new;
        end
        r_fwd_data <= w_new;
    end

    // Saturating count for a pixel, clear for a read.
    always_comb begin
        w_cur = r_fwd_hit ? r_fwd_data : (r_rd_vld ? r_rd_cnt : '0);
        if (r_b1_job.action == mph_pkg::ACT_READ) begin
            w_new             = '0;
            w_result.residual = '0;
            w_result.count    = w_cur;
        end else begin
            w_new             = (w_cur == mph_pkg::COUNT_MAX) ? w_cur
                                : w_cur + mph_pkg::COUNT_W'(1);
            w_result.residual = r_b1_job.key;
            w_result.count    = '0;
        end
    end

    // Output buffer decouples the histogram from the result channel.
    mph_queue #(
        .DEPTH (mph_pkg::OUT_DEPTH),
        .WIDTH ($bits(mph_pkg::t_result))
    ) u_out_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_b1_valid),
        .i_push_data (w_result),
        .i_pop       (w_out_pop),
        .o_head      (w_head),
        .o_count     (w_out_count)
    );

    assign o_res.valid    = (w_out_count != '0);
    assign o_res.residual = w_head.residual;
    assign o_res.count    = w_head.count;
    assign w_out_pop      = o_res.valid && o_res.ready;

    `MPH_ASSERT_NOW(a_back_out_room, i_clk, i_rst_n, r_b1_valid, w_out_count < OCW'(mph_pkg::OUT_DEPTH), "histogram stage finishes with the output buffer full")
    `MPH_ASSERT_NOW(a_back_fwd_source, i_clk, i_rst_n, r_fwd_hit, $past(r_b1_valid), "bypass taken without a histogram write")

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
    import mph_pkg::*;

    localparam int unsigned RING_DEPTH   = MAX_LINE_DEFAULT + 1;
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned REPORT_LIMIT = 10;
    localparam int unsigned RANDOM_BEATS = 1150;
    localparam int unsigned SETTLE_WAIT  = 20;
    localparam int unsigned HOLD_CYCLES  = 250;

    // One input beat as the sender sees it.
    typedef struct packed {
        t_action          action;
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
        logic [PIX_W-1:0] bin;
    } t_beat;

    // Content styles for generated frames.
    typedef enum logic [1:0] {
        TEX_NOISE,
        TEX_SMOOTH,
        TEX_EDGES
    } t_texture;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_data;

    mph_in_if  pix_ch ();
    mph_out_if res_ch ();

    median_predict_with_histogram_top #(
        .MAX_LINE (MAX_LINE_DEFAULT)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_ch),
        .o_res      (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow of the block's pixel and histogram state.
    logic [PIX_W-1:0]   line_ring [RING_DEPTH];
    int unsigned        ring_wr;
    logic [PIX_W-1:0]   prev_pixel;
    int unsigned        frame_pos;
    logic [COUNT_W-1:0] bin_counts [HIST_BINS];
    logic [CFG_W-1:0]   row_len;
    logic [PIX_W-1:0]   last_residual;

    t_result     outputs_due [$];
    int unsigned mismatches;
    int unsigned cycle_count;
    int unsigned burst_left;
    int unsigned hold_request;
    bit          gapless;
    bit          frame_pending;

    // Works out the output beat for one accepted input beat and advances the shadow state.
    function automatic t_result next_outcome(t_beat b);
        t_result          r;
        int unsigned      stride;
        int unsigned      pos;
        logic [PIX_W-1:0] above;
        logic [PIX_W-1:0] above_left;
        logic [PIX_W-1:0] gradient;
        logic [PIX_W-1:0] lo;
        logic [PIX_W-1:0] hi;
        logic [PIX_W-1:0] pred;
        r = '0;
        if (b.action == ACT_READ) begin
            r.count = bin_counts[b.bin];
            bin_counts[b.bin] = '0;
            return r;
        end
        // Zero acts as one and anything wider than the ring allows is clamped.
        if (row_len == 0)
            stride = 1;
        else if (row_len > MAX_LINE_DEFAULT)
            stride = MAX_LINE_DEFAULT;
        else
            stride = row_len;
        pos        = b.frame_start ? 0 : frame_pos;
        above      = line_ring[(ring_wr + RING_DEPTH - stride) % RING_DEPTH];
        above_left = line_ring[(ring_wr + RING_DEPTH - stride - 1) % RING_DEPTH];
        gradient   = above + prev_pixel - above_left;
        lo         = (above < prev_pixel) ? above : prev_pixel;
        hi         = (above < prev_pixel) ? prev_pixel : above;
        if (pos == 0)
            pred = BIAS;
        else if (pos < stride)
            pred = prev_pixel;
        else if (pos == stride)
            pred = above;
        else
            pred = (gradient < lo) ? lo : ((gradient > hi) ? hi : gradient);
        r.residual = b.pixel - pred;
        if (bin_counts[r.residual] != COUNT_MAX)
            bin_counts[r.residual] = bin_counts[r.residual] + 1;
        line_ring[ring_wr] = b.pixel;
        ring_wr            = (ring_wr + 1) % RING_DEPTH;
        prev_pixel         = b.pixel;
        frame_pos          = (pos + 1 > stride + 1) ? stride + 1 : pos + 1;
        last_residual      = r.residual;
        return r;
    endfunction

    function automatic t_beat push_beat(logic [PIX_W-1:0] px, logic fs);
        t_beat b;
        b.action      = ACT_PUSH;
        b.pixel       = px;
        b.frame_start = fs;
        b.bin         = $urandom_range(0, 255);
        return b;
    endfunction

    function automatic t_beat read_beat(logic [PIX_W-1:0] which);
        t_beat b;
        b.action      = ACT_READ;
        b.pixel       = $urandom_range(0, 255);
        b.frame_start = $urandom_range(0, 1);
        b.bin         = which;
        return b;
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    endtask

    // Offers one beat in bursts with random gaps and returns once it is accepted.
    task automatic send_beat(t_beat b);
        int unsigned gap;
        if (burst_left == 0) begin
            if (gapless || $urandom_range(0, 3) == 0)
                gap = 0;
            else
                gap = $urandom_range(1, 7);
            repeat (gap) begin
                @(negedge i_clk);
                pix_ch.valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        // The first pixel after a new row length or a requested new frame opens a fresh frame.
        if (b.action == ACT_PUSH && frame_pending) begin
            b.frame_start = 1'b1;
            frame_pending = 1'b0;
        end
        @(negedge i_clk);
        pix_ch.valid       <= 1'b1;
        pix_ch.action      <= b.action;
        pix_ch.pixel       <= b.pixel;
        pix_ch.frame_start <= b.frame_start;
        pix_ch.bin         <= b.bin;
        do @(posedge i_clk); while (pix_ch.ready !== 1'b1);
        outputs_due.push_back(next_outcome(b));
    endtask

    // Drops valid and waits until every output beat has come back.
    task automatic wait_idle();
        @(negedge i_clk);
        pix_ch.valid <= 1'b0;
        while (outputs_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_line_length(logic [CFG_W-1:0] len);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= len;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        row_len       = len;
        frame_pending = 1'b1;
    endtask

    // Pixels straight after reset with no frame start, at the reset row length, then bin reads.
    task automatic test_unframed_start();
        send_beat(push_beat(8'h00, 1'b0));
        send_beat(push_beat(8'hFF, 1'b0));
        send_beat(push_beat(8'h80, 1'b0));
        send_beat(push_beat(8'h7F, 1'b0));
        send_beat(push_beat(8'h01, 1'b0));
        send_beat(push_beat(8'hFE, 1'b0));
        send_beat(read_beat(8'h80));
        send_beat(read_beat(8'hFF));
        send_beat(read_beat(8'h80));
        send_beat(read_beat(8'h00));
    endtask

    // A short frame with extreme pixels so the gradient wraps, then a frame start at a row boundary and reads.
    task automatic test_directed_frame();
        logic [PIX_W-1:0] pixels [12];
        pixels = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00,
                   8'h80, 8'h01, 8'hFE, 8'h03, 8'hC8, 8'h11};
        set_line_length(13'd3);
        foreach (pixels[i])
            send_beat(push_beat(pixels[i], 1'b0));
        send_beat(push_beat(8'h42, 1'b1));
        send_beat(read_beat(8'h00));
        send_beat(read_beat(8'hFF));
    endtask

    // Row lengths at and beyond both ends, each with a short run of pixels and a read.
    task automatic test_line_length_extremes();
        logic [CFG_W-1:0] widths [6];
        int unsigned      n;
        widths = '{13'd0, 13'd1, 13'd2, 13'd8191, 13'd4097, 13'd4096};
        foreach (widths[i]) begin
            set_line_length(widths[i]);
            if (widths[i] <= 2)
                n = 16;
            else
                n = 24;
            repeat (n)
                send_beat(push_beat($urandom_range(0, 255), 1'b0));
            send_beat(read_beat(last_residual));
        end
    endtask

    // Random phases: new row length, a few frames of random texture, reads mixed in.
    task automatic test_random_frames();
        t_beat            b;
        t_texture         tex;
        logic [CFG_W-1:0] len;
        logic [PIX_W-1:0] walk;
        int unsigned      sent;
        int unsigned      n;
        sent = 0;
        walk = 8'h80;
        while (sent < RANDOM_BEATS) begin
            if ($urandom_range(0, 7) == 0)
                len = $urandom_range(13, 96);
            else
                len = $urandom_range(1, 12);
            set_line_length(len);
            repeat ($urandom_range(1, 3)) begin
                tex           = t_texture'($urandom_range(0, 2));
                n             = len * $urandom_range(1, 5) + $urandom_range(0, len + 1);
                frame_pending = 1'b1;
                repeat (n) begin
                    if ($urandom_range(0, 99) < 12) begin
                        // Half the reads go to a bin that was just counted.
                        if ($urandom_range(0, 1) == 1)
                            b = read_beat(last_residual);
                        else
                            b = read_beat($urandom_range(0, 255));
                    end else begin
                        case (tex)
                            TEX_SMOOTH: walk = walk + $urandom_range(0, 6) - 3;
                            TEX_EDGES:  walk = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
                            default:    walk = $urandom_range(0, 255);
                        endcase
                        // A rare stray frame start breaks the row structure.
                        b = push_beat(walk, $urandom_range(0, 99) == 0);
                    end
                    send_beat(b);
                    sent++;
                end
            end
        end
    endtask

    // The receiver holds off for a long stretch while beats keep coming, so the input stalls.
    task automatic test_output_hold();
        set_line_length(13'd5);
        gapless      = 1'b1;
        hold_request = HOLD_CYCLES;
        repeat (48) begin
            if ($urandom_range(0, 4) == 0)
                send_beat(read_beat(last_residual));
            else
                send_beat(push_beat($urandom_range(0, 255), 1'b0));
        end
        gapless = 1'b0;
    endtask

    // Reads every bin once, which checks all counts and leaves the histogram empty.
    task automatic test_histogram_sweep();
        for (int i = 0; i < HIST_BINS; i++)
            send_beat(read_beat(i[PIX_W-1:0]));
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Cycle count and run limit.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Receiver ready: random stall patterns, runs of full rate, and long hold-offs on request.
    initial begin : drive_ready
        logic [15:0] pattern;
        int unsigned pattern_left;
        int unsigned hold_left;
        pattern      = '1;
        pattern_left = 0;
        hold_left    = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                if (pattern_left == 0) begin
                    case ($urandom_range(0, 3))
                        0:       pattern = '1;
                        1:       pattern = $urandom_range(0, 16'hFFFF);
                        2:       pattern = $urandom_range(0, 16'hFFFF) | $urandom_range(0, 16'hFFFF);
                        default: pattern = $urandom_range(0, 16'hFFFF) & $urandom_range(0, 16'hFFFF);
                    endcase
                    if (pattern == 0)
                        pattern = 16'h0001;
                    pattern_left = $urandom_range(16, 96);
                end
                res_ch.ready <= pattern[0];
                pattern      = {pattern[0], pattern[15:1]};
                pattern_left--;
            end
        end
    end

    // Compare each accepted output beat with the oldest outstanding prediction.
    always @(posedge i_clk) begin : check_outputs
        t_result want;
        if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            if (outputs_due.size() == 0) begin
                report_mismatch($sformatf("output beat with none outstanding: residual %02h count %08h",
                                          res_ch.residual, res_ch.count));
            end else begin
                want = outputs_due.pop_front();
                if (res_ch.residual !== want.residual)
                    report_mismatch($sformatf("residual expected %02h, got %02h",
                                              want.residual, res_ch.residual));
                if (res_ch.count !== want.count)
                    report_mismatch($sformatf("count expected %08h, got %08h",
                                              want.count, res_ch.count));
            end
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_data         = '0;
        pix_ch.valid       = 1'b0;
        pix_ch.action      = ACT_PUSH;
        pix_ch.pixel       = '0;
        pix_ch.frame_start = 1'b0;
        pix_ch.bin         = '0;
        mismatches         = 0;
        burst_left         = 0;
        hold_request       = 0;
        gapless            = 1'b0;
        frame_pending      = 1'b0;
        ring_wr            = 0;
        prev_pixel         = '0;
        frame_pos          = 0;
        last_residual      = '0;
        row_len            = LINE_LENGTH_RESET;
        foreach (line_ring[i])
            line_ring[i] = '0;
        foreach (bin_counts[i])
            bin_counts[i] = '0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_unframed_start();
        test_directed_frame();
        test_line_length_extremes();
        test_random_frames();
        test_output_hold();
        test_histogram_sweep();

        wait_idle();
        repeat (SETTLE_WAIT) @(posedge i_clk);
        if (mismatches == 0 && outputs_due.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/mph_pkg.sv
hw/rtl/mph_ifs.sv
hw/rtl/mph_queue.sv
hw/rtl/mph_front.sv
hw/rtl/mph_back.sv
hw/rtl/median_predict_with_histogram_top.sv
verif/tb_top.sv
